>>> hw/rtl/brst_pkg.sv
package brst_pkg;

	// Operation codes carried by an input item.
	localparam logic [2:0] OP_SUBMIT   = 3'd0;
	localparam logic [2:0] OP_COMPLETE = 3'd1;
	localparam logic [2:0] OP_POLL     = 3'd2;
	localparam logic [2:0] OP_FAIL_ALL = 3'd3;
	localparam logic [2:0] OP_START    = 3'd4;

	// Request kinds.
	localparam logic [1:0] KIND_FLUSH = 2'd2;
	localparam logic [1:0] KIND_UNSUP = 2'd3;

	// Result status codes.
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_BADARG   = 3'd1;
	localparam logic [2:0] ST_BADSTATE = 3'd2;
	localparam logic [2:0] ST_UNSUP    = 3'd3;
	localparam logic [2:0] ST_RANGE    = 3'd4;
	localparam logic [2:0] ST_BLOCK    = 3'd5;
	localparam logic [2:0] ST_IO       = 3'd6;
	localparam logic [2:0] ST_FAILED   = 3'd7;

	// Device completion bytes with a meaning of their own.
	localparam logic [7:0] DEV_OK    = 8'd0;
	localparam logic [7:0] DEV_UNSUP = 8'd2;

	// Configuration register indexes.
	localparam int unsigned    CFG_IDX_W        = 2;
	localparam logic [1:0]     REG_SLOTS_IN_USE = 2'd0;
	localparam logic [1:0]     REG_DISK_SECTORS = 2'd1;

	localparam logic [6:0]  SLOTS_RESET   = 7'd64;
	localparam logic [63:0] SECTORS_RESET = 64'd1;

	// Data transfers must move exactly one sector.
	localparam logic [31:0] SECTOR_BYTES = 32'd512;

	// Commands from the sequencer to the slot table.
	typedef struct packed {
		logic clr_all;
		logic set_busy;
		logic set_done;
		logic set_free;
		logic wr_gen;
		logic wr_res;
		logic rd;
	} tbl_ctl_t;

	// Phase of the selected slot.
	typedef struct packed {
		logic flight;
		logic done;
	} tbl_sts_t;

	// Stored result of a slot.
	typedef struct packed {
		logic [2:0] outcome;
		logic [7:0] fail;
	} slot_res_t;

	function automatic logic [2:0] map_dev_status(input logic [7:0] dev);
		logic [2:0] r;
		if (dev == DEV_OK) begin
			r = ST_OK;
		end else if (dev == DEV_UNSUP) begin
			r = ST_UNSUP;
		end else begin
			r = ST_IO;
		end
		return r;
	endfunction

endpackage

>>> hw/rtl/brst_if.sv
interface brst_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  op;
	logic [1:0]  req_kind;
	logic [63:0] sector_addr;
	logic        has_buffer;
	logic [31:0] length_bytes;
	logic [31:0] gen_tag;
	logic [15:0] slot_in;
	logic [7:0]  dev_status;
	logic [7:0]  fail_code;

	modport source (
		output valid, op, req_kind, sector_addr, has_buffer, length_bytes, gen_tag,
			slot_in, dev_status, fail_code,
		input  ready
	);
	modport sink (
		input  valid, op, req_kind, sector_addr, has_buffer, length_bytes, gen_tag,
			slot_in, dev_status, fail_code,
		output ready
	);
endinterface

interface brst_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status_code;
	logic [5:0]  slot_out;
	logic        publish_valid;
	logic [31:0] gen_out;
	logic [7:0]  fail_out;
	logic [6:0]  in_flight;

	modport source (
		output valid, status_code, slot_out, publish_valid, gen_out, fail_out, in_flight,
		input  ready
	);
	modport sink (
		input  valid, status_code, slot_out, publish_valid, gen_out, fail_out, in_flight,
		output ready
	);
endinterface

interface brst_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [brst_pkg::CFG_IDX_W-1:0]   index;
	logic [63:0]                      data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> hw/rtl/brst_table.sv
module brst_table #(
	parameter int unsigned MAX_SLOTS = 64,
	parameter int unsigned IDXW      = 6
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  brst_pkg::tbl_ctl_t   ctl,
	input  logic [IDXW-1:0]      sel,
	input  logic [31:0]          gen_wdata,
	input  brst_pkg::slot_res_t  res_wdata,
	output brst_pkg::tbl_sts_t   sts,
	output logic [31:0]          rd_gen,
	output brst_pkg::slot_res_t  rd_res
);

	// Phase per slot: free (neither bit), in flight, or done.
	logic [MAX_SLOTS-1:0] flight_q;
	logic [MAX_SLOTS-1:0] done_q;

	logic [31:0]         gen_mem [MAX_SLOTS];
	brst_pkg::slot_res_t res_mem [MAX_SLOTS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flight_q <= '0;
			done_q   <= '0;
		end else if (ctl.clr_all) begin
			flight_q <= '0;
			done_q   <= '0;
		end else begin
			if (ctl.set_busy) begin
				flight_q[sel] <= 1'b1;
			end
			if (ctl.set_done) begin
				flight_q[sel] <= 1'b0;
				done_q[sel]   <= 1'b1;
			end
			if (ctl.set_free) begin
				done_q[sel] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.wr_gen) begin
			gen_mem[sel] <= gen_wdata;
		end
		if (ctl.wr_res) begin
			res_mem[sel] <= res_wdata;
		end
		if (ctl.rd) begin
			rd_gen <= gen_mem[sel];
			rd_res <= res_mem[sel];
		end
	end

	assign sts.flight = flight_q[sel];
	assign sts.done   = done_q[sel];

endmodule

>>> hw/rtl/brst_seq.sv
module brst_seq #(
	parameter int unsigned IDXW = 6,
	parameter int unsigned CAPW = 7
) (
	input  logic                 clk,
	input  logic                 arst_n,
	brst_req_if.sink             req,
	brst_rsp_if.source           rsp,
	input  logic [CAPW-1:0]      cap,
	input  logic [63:0]          disk_sectors,
	output brst_pkg::tbl_ctl_t   ctl,
	output logic [IDXW-1:0]      sel,
	output logic [31:0]          gen_wdata,
	output brst_pkg::slot_res_t  res_wdata,
	input  brst_pkg::tbl_sts_t   sts,
	input  logic [31:0]          rd_gen,
	input  brst_pkg::slot_res_t  rd_res
);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_EXEC = 5'b00010,
		S_SCAN = 5'b00100,
		S_READ = 5'b01000,
		S_RESP = 5'b10000
	} state_t;

	state_t state_q, state_d;

	logic [2:0]  op_q;
	logic [1:0]  kind_q;
	logic [63:0] sector_q;
	logic        buf_q;
	logic [31:0] len_q;
	logic [31:0] gen_q;
	logic [15:0] slot_q;
	logic [7:0]  dev_q;
	logic [7:0]  fcode_q;

	logic [CAPW-1:0] idx_q, idx_d;
	logic [CAPW-1:0] count_q, count_d;
	logic            ready_q, ready_d;

	logic [2:0]  st_q, st_d;
	logic [5:0]  sout_q, sout_d;
	logic        pub_q, pub_d;
	logic [31:0] gout_q, gout_d;
	logic [7:0]  fout_q, fout_d;

	logic        ovalid_q;
	logic [2:0]  o_st_q;
	logic [5:0]  o_slot_q;
	logic        o_pub_q;
	logic [31:0] o_gen_q;
	logic [7:0]  o_fail_q;
	logic [6:0]  o_cnt_q;

	logic take;
	logic load;
	logic slot_ok;
	logic scan_end;

	assign req.ready = (state_q == S_IDLE);
	assign take      = req.valid && req.ready;
	assign load      = (state_q == S_RESP) && (!ovalid_q || rsp.ready);
	assign slot_ok   = 32'(slot_q) < 32'(cap);
	assign scan_end  = (idx_q == cap);

	always_comb begin
		state_d   = state_q;
		idx_d     = idx_q;
		count_d   = count_q;
		ready_d   = ready_q;
		st_d      = st_q;
		sout_d    = sout_q;
		pub_d     = pub_q;
		gout_d    = gout_q;
		fout_d    = fout_q;
		ctl       = '0;
		sel       = (state_q == S_SCAN) ? idx_q[IDXW-1:0] : slot_q[IDXW-1:0];
		gen_wdata = gen_q;
		res_wdata = '{outcome: brst_pkg::ST_BLOCK, fail: 8'h00};

		unique case (state_q)
			S_IDLE: begin
				if (take) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				st_d    = brst_pkg::ST_OK;
				sout_d  = '0;
				pub_d   = 1'b0;
				gout_d  = '0;
				fout_d  = '0;
				idx_d   = '0;
				state_d = S_RESP;
				unique case (op_q)
					brst_pkg::OP_SUBMIT: begin
						priority if (!ready_q) begin
							st_d = brst_pkg::ST_BADSTATE;
						end else if (kind_q == brst_pkg::KIND_UNSUP) begin
							st_d = brst_pkg::ST_UNSUP;
						end else if (kind_q == brst_pkg::KIND_FLUSH) begin
							if (buf_q || len_q != 32'd0) begin
								st_d = brst_pkg::ST_BADARG;
							end else begin
								state_d = S_SCAN;
							end
						end else if (!buf_q || len_q != brst_pkg::SECTOR_BYTES
								|| sector_q >= disk_sectors) begin
							st_d = brst_pkg::ST_RANGE;
						end else begin
							state_d = S_SCAN;
						end
					end
					brst_pkg::OP_COMPLETE: begin
						priority if (!slot_ok) begin
							st_d = brst_pkg::ST_BADARG;
						end else if (!sts.flight) begin
							st_d = brst_pkg::ST_BADSTATE;
						end else begin
							res_wdata = '{outcome: brst_pkg::map_dev_status(dev_q),
								fail: 8'h00};
							ctl.wr_res   = 1'b1;
							ctl.set_done = 1'b1;
						end
					end
					brst_pkg::OP_POLL: begin
						priority if (!slot_ok) begin
							st_d = brst_pkg::ST_BADARG;
						end else if (sts.flight) begin
							sout_d = slot_q[5:0];
							st_d   = brst_pkg::ST_BLOCK;
						end else if (!sts.done) begin
							sout_d = slot_q[5:0];
							st_d   = brst_pkg::ST_BADSTATE;
						end else begin
							sout_d       = slot_q[5:0];
							ctl.rd       = 1'b1;
							ctl.set_free = 1'b1;
							if (count_q != '0) begin
								count_d = count_q - CAPW'(1);
							end
							state_d = S_READ;
						end
					end
					brst_pkg::OP_FAIL_ALL: begin
						if (fcode_q != 8'h00) begin
							state_d = S_SCAN;
						end
					end
					brst_pkg::OP_START: begin
						if (cap == '0) begin
							st_d = brst_pkg::ST_BADARG;
						end else begin
							ctl.clr_all = 1'b1;
							count_d     = '0;
							if (disk_sectors == 64'd0) begin
								ready_d = 1'b0;
								st_d    = brst_pkg::ST_RANGE;
							end else begin
								ready_d = 1'b1;
							end
						end
					end
					default: begin
						st_d = brst_pkg::ST_BADARG;
					end
				endcase
			end
			S_SCAN: begin
				// One slot per cycle; submit stops at the first free slot.
				if (op_q == brst_pkg::OP_SUBMIT) begin
					if (scan_end) begin
						st_d    = brst_pkg::ST_BLOCK;
						state_d = S_RESP;
					end else if (!sts.flight && !sts.done) begin
						ctl.wr_gen   = 1'b1;
						ctl.wr_res   = 1'b1;
						ctl.set_busy = 1'b1;
						count_d      = count_q + CAPW'(1);
						sout_d       = 6'(idx_q);
						pub_d        = 1'b1;
						state_d      = S_RESP;
					end else begin
						idx_d = idx_q + CAPW'(1);
					end
				end else begin
					if (scan_end) begin
						ready_d = 1'b0;
						state_d = S_RESP;
					end else begin
						if (sts.flight) begin
							res_wdata    = '{outcome: brst_pkg::ST_FAILED, fail: fcode_q};
							ctl.wr_res   = 1'b1;
							ctl.set_done = 1'b1;
						end
						idx_d = idx_q + CAPW'(1);
					end
				end
			end
			S_READ: begin
				st_d    = rd_res.outcome;
				gout_d  = rd_gen;
				fout_d  = (rd_res.outcome == brst_pkg::ST_FAILED) ? rd_res.fail : 8'h00;
				state_d = S_RESP;
			end
			S_RESP: begin
				if (load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			ready_q  <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			ready_q <= ready_d;
			if (load) begin
				ovalid_q <= 1'b1;
			end else if (rsp.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			op_q     <= req.op;
			kind_q   <= req.req_kind;
			sector_q <= req.sector_addr;
			buf_q    <= req.has_buffer;
			len_q    <= req.length_bytes;
			gen_q    <= req.gen_tag;
			slot_q   <= req.slot_in;
			dev_q    <= req.dev_status;
			fcode_q  <= req.fail_code;
		end
		idx_q  <= idx_d;
		st_q   <= st_d;
		sout_q <= sout_d;
		pub_q  <= pub_d;
		gout_q <= gout_d;
		fout_q <= fout_d;
		if (load) begin
			o_st_q   <= st_q;
			o_slot_q <= sout_q;
			o_pub_q  <= pub_q;
			o_gen_q  <= gout_q;
			o_fail_q <= fout_q;
			o_cnt_q  <= 7'(count_q);
		end
	end

	assign rsp.valid         = ovalid_q;
	assign rsp.status_code   = o_st_q;
	assign rsp.slot_out      = o_slot_q;
	assign rsp.publish_valid = o_pub_q;
	assign rsp.gen_out       = o_gen_q;
	assign rsp.fail_out      = o_fail_q;
	assign rsp.in_flight     = o_cnt_q;

endmodule

>>> hw/rtl/block_request_slot_tracker.sv
// Block request slot tracker.
// Items arrive on req (valid/ready) and each gives exactly one result on rsp.
// op selects submit, complete, poll, fail all or start; the result carries a
// status, the slot, a publish flag, the stored generation and fail code, and
// the number of requests still outstanding.
// The block takes one item at a time. Each accepted item is first decoded.
// Complete, start and every rejected item then go to the result; poll first
// reads the slot. Submit and a nonzero fail all walk the slot table one slot
// per cycle through the shared scan index, up to cap slots, where cap is the
// smaller of slots_in_use and MAX_SLOTS; submit stops at the lowest free slot.
// req is ready again from the cycle after a result is loaded. Results sit in
// an output register. If the receiver stalls, the next item is still taken
// and worked on, and its result waits until the register empties.
// Configuration is written on cfg, which is always ready. The user must write
// it only while no item is open; the block itself does not enforce this.
// Reset frees every slot, zeroes the outstanding count, restores slots_in_use
// to 64 and disk_sectors to 1, and leaves the block not ready: submits answer
// bad state until a start item succeeds.
module block_request_slot_tracker #(
	parameter int unsigned MAX_SLOTS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	brst_req_if.sink    req,
	brst_rsp_if.source  rsp,
	brst_cfg_if.sink    cfg
);

	localparam int unsigned IDXW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int unsigned CAPW = $clog2(MAX_SLOTS + 1);

	logic [6:0]  slots_q;
	logic [63:0] sectors_q;
	logic [CAPW-1:0] cap;

	brst_pkg::tbl_ctl_t  ctl;
	brst_pkg::tbl_sts_t  sts;
	logic [IDXW-1:0]     sel;
	logic [31:0]         gen_wdata;
	logic [31:0]         rd_gen;
	brst_pkg::slot_res_t res_wdata;
	brst_pkg::slot_res_t rd_res;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_q   <= brst_pkg::SLOTS_RESET;
			sectors_q <= brst_pkg::SECTORS_RESET;
		end else if (cfg.valid && cfg.ready) begin
			if (cfg.index == brst_pkg::REG_SLOTS_IN_USE) begin
				slots_q <= cfg.data[6:0];
			end else if (cfg.index == brst_pkg::REG_DISK_SECTORS) begin
				sectors_q <= cfg.data;
			end
		end
	end

	// A slot count above the table size acts as the table size.
	assign cap = (32'(slots_q) > 32'(MAX_SLOTS)) ? CAPW'(MAX_SLOTS) : CAPW'(slots_q);

	brst_table #(
		.MAX_SLOTS (MAX_SLOTS),
		.IDXW      (IDXW)
	) u_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.sel       (sel),
		.gen_wdata (gen_wdata),
		.res_wdata (res_wdata),
		.sts       (sts),
		.rd_gen    (rd_gen),
		.rd_res    (rd_res)
	);

	brst_seq #(
		.IDXW (IDXW),
		.CAPW (CAPW)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (req),
		.rsp          (rsp),
		.cap          (cap),
		.disk_sectors (sectors_q),
		.ctl          (ctl),
		.sel          (sel),
		.gen_wdata    (gen_wdata),
		.res_wdata    (res_wdata),
		.sts          (sts),
		.rd_gen       (rd_gen),
		.rd_res       (rd_res)
	);

endmodule

>>> bench/testbench.sv
module testbench;
	import brst_pkg::*;

	localparam int unsigned NSLOTS = 64;

	// Operation codes that the block rejects.
	localparam logic [2:0] OP_BAD_FIRST = 3'd5;
	localparam logic [2:0] OP_BAD_LAST  = 3'd7;

	localparam logic [1:0] KIND_READ  = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;

	typedef enum logic [1:0] {SLOT_FREE, SLOT_BUSY, SLOT_DONE} slot_phase_t;

	typedef struct packed {
		logic [2:0]  op;
		logic [1:0]  kind;
		logic [63:0] sector;
		logic        has_buf;
		logic [31:0] len;
		logic [31:0] gen;
		logic [15:0] slot;
		logic [7:0]  dev;
		logic [7:0]  fcode;
	} req_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [5:0]  slot;
		logic        pub;
		logic [31:0] gen;
		logic [7:0]  fail;
		logic [6:0]  inflight;
	} rsp_item_t;

	logic clk = 1'b0;
	logic arst_n;

	always #10 clk = ~clk;

	brst_req_if req_if();
	brst_rsp_if rsp_if();
	brst_cfg_if cfg_if();

	block_request_slot_tracker i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if),
		.cfg    (cfg_if)
	);

	// Tracker state as the testbench expects it to be.
	logic [6:0]   slots_cfg;
	logic [63:0]  sectors_cfg;
	slot_phase_t  phase_q [NSLOTS];
	logic [2:0]   outcome_q [NSLOTS];
	logic [7:0]   fail_q [NSLOTS];
	logic [31:0]  gen_q [NSLOTS];
	int unsigned  outstanding;
	bit           dev_ready;

	rsp_item_t    pending_results [$];
	int unsigned  mismatches;
	bit           gaps_on = 1'b1;

	function automatic int unsigned slot_limit();
		return (slots_cfg > NSLOTS) ? NSLOTS : slots_cfg;
	endfunction

	function automatic void clear_slots();
		for (int i = 0; i < NSLOTS; i++) phase_q[i] = SLOT_FREE;
		outstanding = 0;
	endfunction

	// Applies one item to the expected state and returns the result it must give.
	function automatic rsp_item_t tracker_step(input req_item_t it);
		rsp_item_t   r;
		int unsigned lim;
		int unsigned s;
		bit          claimed;
		r = '0;
		lim = slot_limit();
		s = 32'(it.slot);
		claimed = 1'b0;
		case (it.op)
			OP_SUBMIT: begin
				if (!dev_ready) begin
					r.status = ST_BADSTATE;
				end else if (it.kind == KIND_UNSUP) begin
					r.status = ST_UNSUP;
				end else if (it.kind == KIND_FLUSH && (it.has_buf || it.len != 0)) begin
					r.status = ST_BADARG;
				end else if (it.kind != KIND_FLUSH && (!it.has_buf || it.len != SECTOR_BYTES ||
						it.sector >= sectors_cfg)) begin
					r.status = ST_RANGE;
				end else begin
					r.status = ST_BLOCK;
					for (int i = 0; i < lim && !claimed; i++) begin
						if (phase_q[i] == SLOT_FREE) begin
							phase_q[i] = SLOT_BUSY;
							gen_q[i] = it.gen;
							outcome_q[i] = ST_BLOCK;
							fail_q[i] = '0;
							outstanding++;
							r.status = ST_OK;
							r.slot = 6'(i);
							r.pub = 1'b1;
							claimed = 1'b1;
						end
					end
				end
			end
			OP_COMPLETE: begin
				if (s >= lim) begin
					r.status = ST_BADARG;
				end else if (phase_q[s] != SLOT_BUSY) begin
					r.status = ST_BADSTATE;
				end else begin
					if (it.dev == DEV_OK) outcome_q[s] = ST_OK;
					else if (it.dev == DEV_UNSUP) outcome_q[s] = ST_UNSUP;
					else outcome_q[s] = ST_IO;
					fail_q[s] = '0;
					phase_q[s] = SLOT_DONE;
				end
			end
			OP_POLL: begin
				if (s >= lim) begin
					r.status = ST_BADARG;
				end else begin
					r.slot = s[5:0];
					if (phase_q[s] == SLOT_BUSY) begin
						r.status = ST_BLOCK;
					end else if (phase_q[s] != SLOT_DONE) begin
						r.status = ST_BADSTATE;
					end else begin
						r.status = outcome_q[s];
						r.gen = gen_q[s];
						if (outcome_q[s] == ST_FAILED) r.fail = fail_q[s];
						phase_q[s] = SLOT_FREE;
						if (outstanding > 0) outstanding--;
					end
				end
			end
			OP_FAIL_ALL: begin
				// A zero code is a no-op, but still answers OK.
				if (it.fcode != 0) begin
					for (int i = 0; i < lim; i++) begin
						if (phase_q[i] == SLOT_BUSY) begin
							outcome_q[i] = ST_FAILED;
							fail_q[i] = it.fcode;
							phase_q[i] = SLOT_DONE;
						end
					end
					dev_ready = 1'b0;
				end
			end
			OP_START: begin
				if (lim == 0) begin
					r.status = ST_BADARG;
				end else begin
					clear_slots();
					dev_ready = (sectors_cfg != 0);
					if (sectors_cfg == 0) r.status = ST_RANGE;
				end
			end
			default: r.status = ST_BADARG;
		endcase
		r.inflight = outstanding[6:0];
		return r;
	endfunction

	function automatic req_item_t noise_item();
		req_item_t r;
		r.op = 3'($urandom_range(0, 7));
		r.kind = 2'($urandom);
		r.sector = {$urandom, $urandom};
		r.has_buf = 1'($urandom);
		r.len = $urandom;
		r.gen = $urandom;
		r.slot = $urandom_range(1) ? 16'($urandom_range(0, 70)) : 16'($urandom);
		r.dev = 8'($urandom);
		r.fcode = 8'($urandom);
		return r;
	endfunction

	function automatic req_item_t op_item(input logic [2:0] op);
		req_item_t r;
		r = noise_item();
		r.op = op;
		return r;
	endfunction

	function automatic req_item_t submit_item(input logic [1:0] kind, input logic [63:0] sector,
			input logic has_buf, input logic [31:0] len);
		req_item_t r;
		r = op_item(OP_SUBMIT);
		r.kind = kind;
		r.sector = sector;
		r.has_buf = has_buf;
		r.len = len;
		return r;
	endfunction

	function automatic req_item_t slot_item(input logic [2:0] op, input logic [15:0] slot,
			input logic [7:0] dev);
		req_item_t r;
		r = op_item(op);
		r.slot = slot;
		r.dev = dev;
		return r;
	endfunction

	function automatic req_item_t fail_item(input logic [7:0] code);
		req_item_t r;
		r = op_item(OP_FAIL_ALL);
		r.fcode = code;
		return r;
	endfunction

	function automatic logic [63:0] pick_sector();
		logic [63:0] v;
		v = {$urandom, $urandom};
		if (sectors_cfg != 0) begin
			case ($urandom_range(9))
				0: v = sectors_cfg - 1;
				1: v = 64'($urandom_range(0, 3));
				default: v = v % sectors_cfg;
			endcase
		end
		return v;
	endfunction

	function automatic logic [7:0] pick_dev();
		logic [7:0] d;
		case ($urandom_range(3))
			0: d = DEV_OK;
			1: d = DEV_UNSUP;
			default: d = 8'($urandom);
		endcase
		return d;
	endfunction

	function automatic req_item_t good_submit();
		logic [1:0] kind;
		kind = 2'($urandom_range(0, 2));
		if (kind == KIND_FLUSH) return submit_item(kind, {$urandom, $urandom}, 1'b0, '0);
		return submit_item(kind, pick_sector(), 1'b1, SECTOR_BYTES);
	endfunction

	// Mostly malformed submits, many right at the edges of the checks.
	function automatic req_item_t bad_submit();
		logic [63:0] sector;
		logic [31:0] len;
		case ($urandom_range(3))
			0: sector = sectors_cfg;
			1: sector = sectors_cfg - 1;
			2: sector = 64'hFFFF_FFFF_FFFF_FFFF;
			default: sector = pick_sector();
		endcase
		case ($urandom_range(4))
			0: len = SECTOR_BYTES;
			1: len = '0;
			2: len = SECTOR_BYTES + 1;
			3: len = SECTOR_BYTES - 1;
			default: len = $urandom;
		endcase
		return submit_item(2'($urandom), sector, 1'($urandom_range(1)), len);
	endfunction

	// Mostly well-formed traffic steered by the expected slot table.
	function automatic req_item_t next_item();
		int unsigned lim;
		int          busy [$];
		int          done [$];
		int unsigned roll;
		lim = slot_limit();
		for (int i = 0; i < lim; i++) begin
			if (phase_q[i] == SLOT_BUSY) busy.push_back(i);
			if (phase_q[i] == SLOT_DONE) done.push_back(i);
		end
		if (!dev_ready && $urandom_range(3) != 0) return op_item(OP_START);
		roll = $urandom_range(99);
		if (roll < 35) return good_submit();
		if (roll < 52 && busy.size() != 0)
			return slot_item(OP_COMPLETE, 16'(busy[$urandom_range(busy.size() - 1)]),
				pick_dev());
		if (roll < 70 && done.size() != 0)
			return slot_item(OP_POLL, 16'(done[$urandom_range(done.size() - 1)]),
				8'($urandom));
		if (roll < 76 && lim != 0)
			return slot_item($urandom_range(1) ? OP_POLL : OP_COMPLETE,
				16'($urandom_range(lim - 1)), pick_dev());
		if (roll < 82) return bad_submit();
		if (roll < 84) return fail_item($urandom_range(3) == 0 ? 8'd0 : 8'($urandom));
		if (roll < 86) return op_item(OP_START);
		if (roll < 88) return op_item(3'($urandom_range(OP_BAD_FIRST, OP_BAD_LAST)));
		if (roll < 95) return noise_item();
		return good_submit();
	endfunction

	task automatic send_item(input req_item_t it);
		while (gaps_on && $urandom_range(99) < 14) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.op <= it.op;
		req_if.req_kind <= it.kind;
		req_if.sector_addr <= it.sector;
		req_if.has_buffer <= it.has_buf;
		req_if.length_bytes <= it.len;
		req_if.gen_tag <= it.gen;
		req_if.slot_in <= it.slot;
		req_if.dev_status <= it.dev;
		req_if.fail_code <= it.fcode;
		do @(posedge clk); while (!req_if.ready);
		pending_results.push_back(tracker_step(it));
	endtask

	// Lets every result out, then gives a slot scan time to finish.
	task automatic wait_idle();
		req_if.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= val;
		do @(posedge clk); while (!cfg_if.ready);
		if (idx == REG_SLOTS_IN_USE) slots_cfg = val[6:0];
		else sectors_cfg = val;
		cfg_if.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic test_directed();
		req_item_t it;
		send_item(submit_item(KIND_READ, '0, 1'b1, SECTOR_BYTES));
		send_item(op_item(OP_START));
		it = submit_item(KIND_READ, '0, 1'b1, SECTOR_BYTES);
		it.gen = '0;
		send_item(it);
		send_item(submit_item(KIND_WRITE, 64'd1, 1'b1, SECTOR_BYTES));
		send_item(submit_item(KIND_READ, '0, 1'b0, SECTOR_BYTES));
		send_item(submit_item(KIND_WRITE, '0, 1'b1, SECTOR_BYTES - 1));
		send_item(submit_item(KIND_UNSUP, '0, 1'b1, SECTOR_BYTES));
		send_item(submit_item(KIND_FLUSH, '0, 1'b1, '0));
		send_item(submit_item(KIND_FLUSH, '0, 1'b0, 32'hFFFF_FFFF));
		send_item(submit_item(KIND_FLUSH, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0));
		send_item(slot_item(OP_COMPLETE, 16'd0, DEV_OK));
		send_item(slot_item(OP_COMPLETE, 16'd1, DEV_UNSUP));
		send_item(slot_item(OP_POLL, 16'd0, '0));
		send_item(slot_item(OP_POLL, 16'd1, '0));
		send_item(slot_item(OP_COMPLETE, 16'd64, DEV_OK));
		send_item(slot_item(OP_POLL, 16'hFFFF, DEV_OK));
		send_item(slot_item(OP_COMPLETE, 16'd5, DEV_OK));
		send_item(slot_item(OP_POLL, 16'd5, DEV_OK));
		it = submit_item(KIND_WRITE, '0, 1'b1, SECTOR_BYTES);
		it.gen = 32'hFFFF_FFFF;
		send_item(it);
		send_item(slot_item(OP_POLL, 16'd0, '0));
		send_item(slot_item(OP_COMPLETE, 16'd0, 8'hFF));
		send_item(slot_item(OP_COMPLETE, 16'd0, DEV_OK));
		send_item(slot_item(OP_POLL, 16'd0, '0));
		send_item(good_submit());
		send_item(fail_item(8'd0));
		send_item(fail_item(8'hFF));
		send_item(good_submit());
		send_item(slot_item(OP_POLL, 16'd0, '0));
		send_item(op_item(OP_BAD_LAST));
	endtask

	task automatic test_config_edges();
		wait_idle();
		write_reg(REG_DISK_SECTORS, '0);
		send_item(op_item(OP_START));
		send_item(good_submit());
		wait_idle();
		write_reg(REG_SLOTS_IN_USE, '0);
		send_item(op_item(OP_START));
		send_item(slot_item(OP_COMPLETE, 16'd0, DEV_OK));
		wait_idle();
		write_reg(REG_SLOTS_IN_USE, 64'd3);
		write_reg(REG_DISK_SECTORS, 64'hFFFF_FFFF_FFFF_FFFF);
		send_item(op_item(OP_START));
		send_item(submit_item(KIND_READ, 64'hFFFF_FFFF_FFFF_FFFE, 1'b1, SECTOR_BYTES));
		send_item(submit_item(KIND_WRITE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, SECTOR_BYTES));
		send_item(good_submit());
		send_item(good_submit());
		send_item(good_submit());
		// Shrinking the table hides the upper slots without touching them.
		wait_idle();
		write_reg(REG_SLOTS_IN_USE, 64'd1);
		send_item(slot_item(OP_POLL, 16'd2, '0));
		send_item(slot_item(OP_COMPLETE, 16'd0, DEV_OK));
		send_item(slot_item(OP_POLL, 16'd0, '0));
		send_item(good_submit());
		wait_idle();
		write_reg(REG_SLOTS_IN_USE, 64'd3);
		send_item(slot_item(OP_COMPLETE, 16'd2, DEV_UNSUP));
		send_item(slot_item(OP_POLL, 16'd2, '0));
	endtask

	task automatic test_full_table();
		wait_idle();
		write_reg(REG_SLOTS_IN_USE, 64'd127);
		send_item(op_item(OP_START));
		repeat (NSLOTS + 1) send_item(good_submit());
		send_item(fail_item(8'($urandom_range(1, 255))));
		send_item(slot_item(OP_POLL, 16'(NSLOTS - 1), '0));
		send_item(slot_item(OP_POLL, 16'd0, '0));
	endtask

	task automatic test_random_traffic(input logic [6:0] slots, input logic [63:0] sectors,
			input int unsigned count, input bit gaps);
		wait_idle();
		write_reg(REG_SLOTS_IN_USE, 64'(slots));
		write_reg(REG_DISK_SECTORS, sectors);
		gaps_on = gaps;
		send_item(op_item(OP_START));
		repeat (count) send_item(next_item());
		gaps_on = 1'b1;
	endtask

	initial begin
		rsp_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			rsp_if.ready <= !(gaps_on && $urandom_range(99) < 14);
		end
	end

	always @(posedge clk) begin
		rsp_item_t got;
		rsp_item_t want;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			got.status = rsp_if.status_code;
			got.slot = rsp_if.slot_out;
			got.pub = rsp_if.publish_valid;
			got.gen = rsp_if.gen_out;
			got.fail = rsp_if.fail_out;
			got.inflight = rsp_if.in_flight;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result with nothing outstanding: status %0d slot %0d",
						got.status, got.slot);
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch: exp st %0d slot %0d pub %0b gen %h fail %h cnt %0d,",
							" got st %0d slot %0d pub %0b gen %h fail %h cnt %0d"},
							want.status, want.slot, want.pub, want.gen, want.fail,
							want.inflight, got.status, got.slot, got.pub, got.gen,
							got.fail, got.inflight);
				end
			end
		end
	end

	initial begin
		#20_000_000;
		$display("FAIL");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		req_if.valid = 1'b0;
		req_if.op = OP_SUBMIT;
		req_if.req_kind = KIND_READ;
		req_if.sector_addr = '0;
		req_if.has_buffer = 1'b0;
		req_if.length_bytes = '0;
		req_if.gen_tag = '0;
		req_if.slot_in = '0;
		req_if.dev_status = DEV_OK;
		req_if.fail_code = '0;
		cfg_if.valid = 1'b0;
		cfg_if.index = REG_SLOTS_IN_USE;
		cfg_if.data = '0;
		mismatches = 0;
		slots_cfg = SLOTS_RESET;
		sectors_cfg = SECTORS_RESET;
		dev_ready = 1'b0;
		clear_slots();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_config_edges();
		test_full_table();
		test_random_traffic(7'd64, 64'd1000, 55, 1'b1);
		test_random_traffic(7'd1, 64'd1, 55, 1'b1);
		test_random_traffic(7'd127, 64'hFFFF_FFFF_FFFF_FFFF, 55, 1'b1);
		test_random_traffic(7'd5, 64'd100, 55, 1'b1);
		test_random_traffic(7'd33, 64'h1_0000_0000, 55, 1'b0);
		test_random_traffic(7'd64, {$urandom, $urandom} | 64'd1, 55, 1'b1);

		req_if.valid <= 1'b0;
		for (int n = 0; n < 50000 && pending_results.size() != 0; n++) @(posedge clk);
		repeat (100) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
